// ===== rtl/ctpp_pkg.sv =====
// ctpp_pkg: shared constants and codes for the cashtoken prefix parser
// holds marker byte, bitfield masks, byte kind and status codes
// no dependencies
package ctpp_pkg;

	// default number of category bytes after the marker
	localparam int CATEGORY_BYTES = 32;

	// field counter width: category index up to 63, compact-size byte index up to 8
	localparam int FC_W = 6;

	localparam logic [7:0] MARK_BYTE  = 8'hEF;
	localparam logic [7:0] NFT_BIT    = 8'h20;
	localparam logic [7:0] COMMIT_BIT = 8'h40;
	localparam logic [7:0] AMOUNT_BIT = 8'h10;
	localparam logic [7:0] CAP_BITS   = 8'h0F;

	// compact-size prefix bytes
	localparam logic [7:0] CS_2BYTE = 8'hFD;
	localparam logic [7:0] CS_4BYTE = 8'hFE;

	// capability nibble codes and decoded capability
	localparam logic [3:0] CAP_CODE_MUTABLE = 4'd1;
	localparam logic [3:0] CAP_CODE_MINTING = 4'd2;
	localparam logic [1:0] CAP_NONE         = 2'd0;
	localparam logic [1:0] CAP_MUTABLE      = 2'd1;
	localparam logic [1:0] CAP_MINTING      = 2'd2;

	typedef logic [2:0] kind_t;
	localparam kind_t KIND_NONE     = 3'd0;
	localparam kind_t KIND_MARKER   = 3'd1;
	localparam kind_t KIND_CATEGORY = 3'd2;
	localparam kind_t KIND_BITFIELD = 3'd3;
	localparam kind_t KIND_LENGTH   = 3'd4;
	localparam kind_t KIND_COMMIT   = 3'd5;
	localparam kind_t KIND_AMOUNT   = 3'd6;
	localparam kind_t KIND_TRAIL    = 3'd7;

	typedef logic [1:0] status_t;
	localparam status_t ST_OK        = 2'd0;
	localparam status_t ST_NO_TOKEN  = 2'd1;
	localparam status_t ST_TRUNCATED = 2'd2;

endpackage

// ===== rtl/cashtoken_prefix_parser_unit.sv =====
// cashtoken_prefix_parser_unit: byte-serial token prefix parser with a result register
// depends on ctpp_pkg for codes and masks
// single module, no submodules
//
// Takes one locking-script byte per request on the slave stream and returns one tagged
// result per byte on the master stream. The first byte of a script must be the 0xEF marker,
// then CATEGORY_BYTES category bytes, one bitfield byte, an optional compact-size commitment
// length plus that many commitment bytes, and an optional compact-size amount. Every byte is
// tagged with its kind in m_tuser. The byte on which the prefix completes or fails carries
// prefix_done with a status (ok, no token marker, truncated) and the decoded fields; on all
// other bytes status and decoded fields are zero. s_tlast ends a script and returns the parser
// to idle. Rate: one byte per clock cycle while m_tready is high. The parse state is
// updated in the same cycle a byte is taken, and the result lands in a single output register;
// s_tready is high whenever that register is empty or being drained in the same cycle.
module cashtoken_prefix_parser_unit #(
	parameter int CATEGORY_BYTES = ctpp_pkg::CATEGORY_BYTES
) (
	input  logic         clk,
	input  logic         arst_n,
	// slave stream: script bytes
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // [7:0] data_byte
	input  logic         s_tlast,   // last_byte
	// master stream: tagged results
	output logic         m_tvalid,
	input  logic         m_tready,
	// [7:0] byte_out, [8] prefix_done, [10:9] status, [11] nft flag, [13:12] capability,
	// [14] commit_flag, [78:15] commitment_length, [79] amount_flag, [143:80] token_amount
	output logic [143:0] m_tdata,
	output logic [2:0]   m_tuser    // [2:0] byte_kind
);

	localparam int FC_W  = ctpp_pkg::FC_W;
	localparam int CNT_W = FC_W + 1;

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_CAT,
		PH_BITS,
		PH_CLEN,
		PH_CLEN_MORE,
		PH_COMMIT,
		PH_AMT,
		PH_AMT_MORE,
		PH_TRAIL,
		PH_NOTOK
	} phase_t;

	// parse state
	phase_t            phase_q;
	logic [FC_W-1:0]   field_count_q;
	logic [7:0]        flag_bits_q;
	logic [63:0]       varint_acc_q;
	logic [3:0]        varint_left_q;
	logic [63:0]       commit_left_q;
	logic [63:0]       commit_len_q;

	// result register
	logic              m_valid_q;
	ctpp_pkg::kind_t   kind_q;
	logic [7:0]        byte_q;
	logic              done_q;
	ctpp_pkg::status_t status_q;
	logic              nft_q;
	logic [1:0]        cap_q;
	logic              hc_q;
	logic [63:0]       clen_q;
	logic              ha_q;
	logic [63:0]       amt_q;

	logic              accept;

	// next-state and result of the current byte
	phase_t            phase_n;
	logic [FC_W-1:0]   field_count_n;
	logic [7:0]        flag_bits_n;
	logic [63:0]       varint_acc_n;
	logic [3:0]        varint_left_n;
	logic [63:0]       commit_left_n;
	logic [63:0]       commit_len_n;
	ctpp_pkg::kind_t   kind_n;
	logic              fin;
	logic              notok;
	logic              vdone;

	// compact-size helpers
	logic              first_done;
	logic [3:0]        first_left;
	logic [63:0]       more_acc;
	logic [3:0]        more_left;
	logic [63:0]       commit_dec;
	logic [3:0]        cap_code;

	// result fields
	logic              r_done;
	ctpp_pkg::status_t r_status;
	logic              r_nft;
	logic [1:0]        r_cap;
	logic              r_hc;
	logic [63:0]       r_clen;
	logic              r_ha;
	logic [63:0]       r_amt;

	// output register frees up the input side whenever it drains
	assign s_tready = !m_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	// first byte of a compact size: value itself, or count of following bytes
	assign first_done = (s_tdata < ctpp_pkg::CS_2BYTE);
	always_comb begin
		if (s_tdata == ctpp_pkg::CS_2BYTE) begin
			first_left = 4'd2;
		end else if (s_tdata == ctpp_pkg::CS_4BYTE) begin
			first_left = 4'd4;
		end else begin
			first_left = 4'd8;
		end
	end

	// little-endian continuation byte, placed by the byte index
	assign more_acc   = varint_acc_q | ({56'd0, s_tdata} << {field_count_q[2:0], 3'b000});
	assign more_left  = varint_left_q - 4'd1;
	assign commit_dec = commit_left_q - 64'd1;

	always_comb begin
		phase_n       = phase_q;
		field_count_n = field_count_q;
		flag_bits_n   = flag_bits_q;
		varint_acc_n  = varint_acc_q;
		varint_left_n = varint_left_q;
		commit_left_n = commit_left_q;
		commit_len_n  = commit_len_q;
		kind_n        = ctpp_pkg::KIND_NONE;
		fin           = 1'b0;
		notok         = 1'b0;
		vdone         = 1'b0;

		unique case (phase_q)
			PH_IDLE: begin
				if (s_tdata == ctpp_pkg::MARK_BYTE) begin
					kind_n        = ctpp_pkg::KIND_MARKER;
					field_count_n = '0;
					flag_bits_n   = '0;
					varint_acc_n  = '0;
					varint_left_n = '0;
					commit_left_n = '0;
					commit_len_n  = '0;
					phase_n       = PH_CAT;
				end else begin
					notok   = 1'b1;
					phase_n = PH_NOTOK;
				end
			end
			PH_CAT: begin
				kind_n = ctpp_pkg::KIND_CATEGORY;
				if ({1'b0, field_count_q} + CNT_W'(1) >= CNT_W'(CATEGORY_BYTES)) begin
					field_count_n = '0;
					phase_n       = PH_BITS;
				end else begin
					field_count_n = field_count_q + FC_W'(1);
				end
			end
			PH_BITS: begin
				kind_n      = ctpp_pkg::KIND_BITFIELD;
				flag_bits_n = s_tdata;
				if ((s_tdata & ctpp_pkg::COMMIT_BIT) != 8'd0) begin
					phase_n = PH_CLEN;
				end else if ((s_tdata & ctpp_pkg::AMOUNT_BIT) != 8'd0) begin
					phase_n = PH_AMT;
				end else begin
					fin = 1'b1;
				end
			end
			PH_CLEN, PH_CLEN_MORE: begin
				kind_n = ctpp_pkg::KIND_LENGTH;
				if (phase_q == PH_CLEN) begin
					field_count_n = '0;
					if (first_done) begin
						varint_acc_n  = {56'd0, s_tdata};
						varint_left_n = '0;
						vdone         = 1'b1;
					end else begin
						varint_acc_n  = '0;
						varint_left_n = first_left;
						phase_n       = PH_CLEN_MORE;
					end
				end else begin
					varint_acc_n  = more_acc;
					field_count_n = field_count_q + FC_W'(1);
					varint_left_n = more_left;
					vdone         = (more_left == 4'd0);
				end
				if (vdone) begin
					commit_len_n  = varint_acc_n;
					commit_left_n = varint_acc_n;
					if (varint_acc_n != 64'd0) begin
						phase_n = PH_COMMIT;
					end else if ((flag_bits_q & ctpp_pkg::AMOUNT_BIT) != 8'd0) begin
						phase_n = PH_AMT;
					end else begin
						fin = 1'b1;
					end
				end
			end
			PH_COMMIT: begin
				kind_n        = ctpp_pkg::KIND_COMMIT;
				commit_left_n = commit_dec;
				if (commit_dec == 64'd0) begin
					if ((flag_bits_q & ctpp_pkg::AMOUNT_BIT) != 8'd0) begin
						phase_n = PH_AMT;
					end else begin
						fin = 1'b1;
					end
				end
			end
			PH_AMT, PH_AMT_MORE: begin
				kind_n = ctpp_pkg::KIND_AMOUNT;
				if (phase_q == PH_AMT) begin
					field_count_n = '0;
					if (first_done) begin
						varint_acc_n  = {56'd0, s_tdata};
						varint_left_n = '0;
						fin           = 1'b1;
					end else begin
						varint_acc_n  = '0;
						varint_left_n = first_left;
						phase_n       = PH_AMT_MORE;
					end
				end else begin
					varint_acc_n  = more_acc;
					field_count_n = field_count_q + FC_W'(1);
					varint_left_n = more_left;
					fin           = (more_left == 4'd0);
				end
			end
			PH_TRAIL: begin
				kind_n = ctpp_pkg::KIND_TRAIL;
			end
			default: begin
				phase_n = PH_NOTOK;
			end
		endcase

		if (fin) begin
			phase_n = PH_TRAIL;
		end

		// decoded fields on completion
		cap_code = flag_bits_n[3:0] & ctpp_pkg::CAP_BITS[3:0];
		r_done   = 1'b0;
		r_status = ctpp_pkg::ST_OK;
		r_nft    = 1'b0;
		r_cap    = ctpp_pkg::CAP_NONE;
		r_hc     = 1'b0;
		r_clen   = '0;
		r_ha     = 1'b0;
		r_amt    = '0;
		if (fin) begin
			r_done = 1'b1;
			r_nft  = ((flag_bits_n & ctpp_pkg::NFT_BIT) != 8'd0);
			r_hc   = ((flag_bits_n & ctpp_pkg::COMMIT_BIT) != 8'd0);
			r_ha   = ((flag_bits_n & ctpp_pkg::AMOUNT_BIT) != 8'd0);
			if (r_nft && cap_code == ctpp_pkg::CAP_CODE_MUTABLE) begin
				r_cap = ctpp_pkg::CAP_MUTABLE;
			end else if (r_nft && cap_code == ctpp_pkg::CAP_CODE_MINTING) begin
				r_cap = ctpp_pkg::CAP_MINTING;
			end
			r_clen = r_hc ? commit_len_n : 64'd0;
			r_amt  = r_ha ? varint_acc_n : 64'd0;
		end else if (notok) begin
			r_done   = 1'b1;
			r_status = ctpp_pkg::ST_NO_TOKEN;
		end

		// end of script: an unfinished prefix is truncated
		if (s_tlast) begin
			if (phase_n != PH_TRAIL && phase_n != PH_NOTOK) begin
				r_done   = 1'b1;
				r_status = ctpp_pkg::ST_TRUNCATED;
			end
			phase_n = PH_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			field_count_q <= '0;
			flag_bits_q   <= '0;
			varint_acc_q  <= '0;
			varint_left_q <= '0;
			commit_left_q <= '0;
			commit_len_q  <= '0;
			m_valid_q     <= 1'b0;
		end else begin
			if (accept) begin
				phase_q       <= phase_n;
				field_count_q <= field_count_n;
				flag_bits_q   <= flag_bits_n;
				varint_acc_q  <= varint_acc_n;
				varint_left_q <= varint_left_n;
				commit_left_q <= commit_left_n;
				commit_len_q  <= commit_len_n;
				m_valid_q     <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// result payload, loaded with each request
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q   <= kind_n;
			byte_q   <= s_tdata;
			done_q   <= r_done;
			status_q <= r_status;
			nft_q    <= r_nft;
			cap_q    <= r_cap;
			hc_q     <= r_hc;
			clen_q   <= r_clen;
			ha_q     <= r_ha;
			amt_q    <= r_amt;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = kind_q;
	assign m_tdata  = {amt_q, ha_q, clen_q, hc_q, cap_q, nft_q, status_q, done_q, byte_q};

	// a script end always sends the parser back to idle
	a_last_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && s_tlast) |=> (phase_q == PH_IDLE))
		else $error("parser not idle after last byte");

	// a nonzero status only appears with prefix_done
	a_status_done: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && status_q != ctpp_pkg::ST_OK) |-> done_q)
		else $error("status without prefix_done");

	// decoded length and amount are zero when the matching field is absent
	a_absent_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q |-> ((hc_q || clen_q == 64'd0) && (ha_q || amt_q == 64'd0)))
		else $error("decoded value for an absent field");

	// a held result keeps the parser frozen
	a_stall_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && !m_tready) |=> $stable(phase_q))
		else $error("parse state moved during output stall");

endmodule
